FILE: rtl/core/nearest_palette_color_search_top_defines.svh
`ifndef NEAREST_PALETTE_COLOR_SEARCH_TOP_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define NPCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define NPCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/core/npcs_pkg.sv
package npcs_pkg;

    localparam int CHAN_W            = 8;
    localparam int INDEX_W           = 8;
    localparam int COUNT_W           = 9;
    localparam int DIST_W            = 10;
    localparam int ENTRY_W           = 4 * CHAN_W;
    localparam int PALETTE_DEPTH_DEF = 256;
    localparam int APB_ADDR_W        = 3;
    localparam int APB_DATA_W        = 32;

    localparam logic OP_WRITE = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic [CHAN_W-1:0] alpha;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
    } color_t;

endpackage

FILE: rtl/core/npcs_ram.sv
module npcs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: rtl/core/npcs_dist.sv
module npcs_dist
    import npcs_pkg::*;
(
    input  color_t            query,
    input  color_t            entry,
    output logic [DIST_W-1:0] distance
);

    logic [CHAN_W-1:0] d_red;
    logic [CHAN_W-1:0] d_green;
    logic [CHAN_W-1:0] d_blue;
    logic [CHAN_W-1:0] d_alpha;

    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] x,
                                                   input logic [CHAN_W-1:0] y);
        abs_diff = (x > y) ? (x - y) : (y - x);
    endfunction

    assign d_red   = abs_diff(query.red,   entry.red);
    assign d_green = abs_diff(query.green, entry.green);
    assign d_blue  = abs_diff(query.blue,  entry.blue);
    assign d_alpha = abs_diff(query.alpha, entry.alpha);

    assign distance = DIST_W'(d_red) + DIST_W'(d_green) + DIST_W'(d_blue) + DIST_W'(d_alpha);

endmodule

FILE: rtl/core/nearest_palette_color_search_top.sv
// Palette quantizer. A write transaction (opcode 0) stores an RGBA entry; a query (opcode 1)
// scans palette entries 0 to min(palette_count, PALETTE_DEPTH)-1 except transparent_index, one
// per cycle through the single palette RAM read port and the shared distance unit; each read
// passes the RAM output and distance registers before the compare, and the result is offered
// once the output register is free. A query with alpha 0 or with palette_count 0 skips the
// scan and offers transparent_index. The input is not ready while a query is in flight or its
// result is still waiting to be loaded into the output register. Reading an entry never
// written gives an undefined distance for that entry.
`include "nearest_palette_color_search_top_defines.svh"

module nearest_palette_color_search_top
    import npcs_pkg::*;
#(
    parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  logic                  opcode,
    input  logic [INDEX_W-1:0]    entry_index,
    input  logic [CHAN_W-1:0]     red,
    input  logic [CHAN_W-1:0]     green,
    input  logic [CHAN_W-1:0]     blue,
    input  logic [CHAN_W-1:0]     alpha,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [INDEX_W-1:0]    palette_index,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int AW = $clog2(PALETTE_DEPTH);
    localparam int CW = $clog2(PALETTE_DEPTH + 1);

    localparam logic REG_COUNT = 1'b0;
    localparam logic REG_TRANS = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t              state_reg, state_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    logic [INDEX_W-1:0]  trans_reg, trans_next;
    logic [CW-1:0]       cnt_reg, cnt_next;
    logic [CW-1:0]       limit_reg, limit_next;
    logic                s1_act_reg, s1_act_next;
    logic                s1_use_reg, s1_use_next;
    logic                s2_act_reg, s2_act_next;
    logic                s2_use_reg, s2_use_next;
    logic                have_best_reg, have_best_next;
    logic [AW-1:0]       best_idx_reg, best_idx_next;
    logic [DIST_W-1:0]   min_sum_reg, min_sum_next;
    logic [INDEX_W-1:0]  result_reg, result_next;
    logic                out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0]  out_index_reg, out_index_next;

    color_t              query_reg;
    logic [AW-1:0]       s1_idx_reg;
    logic [AW-1:0]       s2_idx_reg;
    logic [DIST_W-1:0]   dist_reg;

    logic                in_accept;
    logic                cfg_write;
    logic                ram_we;
    logic                ram_re;
    logic [ENTRY_W-1:0]  ram_rdata;
    color_t              wr_color;
    logic [DIST_W-1:0]   distance;

    assign in_ready      = (state_reg == ST_IDLE);
    assign in_accept     = in_valid && in_ready;
    assign out_valid     = out_valid_reg;
    assign palette_index = out_index_reg;
    assign pready        = 1'b1;
    assign cfg_write     = psel && penable && pwrite;

    assign wr_color.red   = red;
    assign wr_color.green = green;
    assign wr_color.blue  = blue;
    assign wr_color.alpha = alpha;

    assign ram_we = in_accept && (opcode == OP_WRITE) && (32'(entry_index) < PALETTE_DEPTH);
    assign ram_re = (state_reg == ST_SCAN);

    npcs_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (entry_index[AW-1:0]),
        .wdata (wr_color),
        .re    (ram_re),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    npcs_dist u_dist (
        .query    (query_reg),
        .entry    (color_t'(ram_rdata)),
        .distance (distance)
    );

    always_comb
    begin
        case (paddr[2])
            REG_COUNT: prdata = APB_DATA_W'(count_reg);
            REG_TRANS: prdata = APB_DATA_W'(trans_reg);
            default:   prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        trans_next     = trans_reg;
        cnt_next       = cnt_reg;
        limit_next     = limit_reg;
        s1_act_next    = 1'b0;
        s1_use_next    = 1'b0;
        s2_act_next    = s1_act_reg;
        s2_use_next    = s1_use_reg;
        have_best_next = have_best_reg;
        best_idx_next  = best_idx_reg;
        min_sum_next   = min_sum_reg;
        result_next    = result_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_index_next = out_index_reg;

        if (cfg_write)
        begin
            case (paddr[2])
                REG_COUNT: count_next = pwdata[COUNT_W-1:0];
                REG_TRANS: trans_next = pwdata[INDEX_W-1:0];
                default:   count_next = count_reg;
            endcase
        end

        // strict less-than keeps the lowest index on a tie
        if (s2_act_reg && s2_use_reg && (!have_best_reg || (dist_reg < min_sum_reg)))
        begin
            have_best_next = 1'b1;
            best_idx_next  = s2_idx_reg;
            min_sum_next   = dist_reg;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_accept && (opcode == OP_QUERY))
                begin
                    if ((alpha == '0) || (count_reg == '0))
                    begin
                        result_next = trans_reg;
                        state_next  = ST_DONE;
                    end
                    else
                    begin
                        cnt_next       = '0;
                        limit_next     = (32'(count_reg) >= PALETTE_DEPTH) ?
                                         CW'(PALETTE_DEPTH) : CW'(count_reg);
                        have_best_next = 1'b0;
                        best_idx_next  = '0;
                        state_next     = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                s1_act_next = 1'b1;
                s1_use_next = (COUNT_W'(cnt_reg) != COUNT_W'(trans_reg));
                cnt_next    = CW'(cnt_reg + 1'b1);
                if (CW'(cnt_reg + 1'b1) == limit_reg)
                begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN:
            begin
                if (!s1_act_reg && !s2_act_reg)
                begin
                    result_next = INDEX_W'(best_idx_reg);
                    state_next  = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = result_reg;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            trans_reg     <= '0;
            cnt_reg       <= '0;
            limit_reg     <= '0;
            s1_act_reg    <= 1'b0;
            s1_use_reg    <= 1'b0;
            s2_act_reg    <= 1'b0;
            s2_use_reg    <= 1'b0;
            have_best_reg <= 1'b0;
            best_idx_reg  <= '0;
            min_sum_reg   <= '0;
            result_reg    <= '0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            trans_reg     <= trans_next;
            cnt_reg       <= cnt_next;
            limit_reg     <= limit_next;
            s1_act_reg    <= s1_act_next;
            s1_use_reg    <= s1_use_next;
            s2_act_reg    <= s2_act_next;
            s2_use_reg    <= s2_use_next;
            have_best_reg <= have_best_next;
            best_idx_reg  <= best_idx_next;
            min_sum_reg   <= min_sum_next;
            result_reg    <= result_next;
            out_valid_reg <= out_valid_next;
            out_index_reg <= out_index_next;
        end
    end

    // query color and scan pipeline payload
    always_ff @(posedge clk)
    begin
        if (in_accept && (opcode == OP_QUERY))
        begin
            query_reg <= wr_color;
        end
        s1_idx_reg <= cnt_reg[AW-1:0];
        s2_idx_reg <= s1_idx_reg;
        dist_reg   <= distance;
    end

    `NPCS_ASSERT_NOW(a_busy_not_ready, s1_act_reg || s2_act_reg, !in_ready,
        "scan pipeline active while input is ready")
    `NPCS_ASSERT_NOW(a_best_in_range, have_best_reg, CW'(best_idx_reg) < limit_reg,
        "best index outside scanned range")
    `NPCS_ASSERT_NEXT(a_transparent_query,
        in_accept && (opcode == OP_QUERY) && (alpha == '0),
        (state_reg == ST_DONE) && (result_reg == $past(trans_reg)),
        "alpha zero query did not answer transparent index")

endmodule
